// File: src/v2a_pkg.sv
// v2a_pkg: shared types, constants and helper functions for the 2-D vector ALU.
// Used by v2a_sqrt, v2a_div and vector2_alu_top. No dependencies.
package v2a_pkg;

	localparam int FRAC      = 16;            // Q16.16 fraction bits
	localparam int RB        = 32;            // square root result bits
	localparam int QB        = 33;            // quotient bits kept before saturation
	localparam int NW        = 48;            // dividend width: 32 bits shifted by FRAC
	localparam int CMPW      = 32 + QB;       // width for divisor shift compares
	localparam int CW        = 42;            // rotation datapath width, 8 guard bits
	localparam int ZW        = 20;            // residual angle width
	localparam int GUARD     = 8;
	localparam int ROT_STEPS = 17;
	localparam int SHIFT_K   = 30 - GUARD;    // gain product back to Q16.16 plus guard

	localparam logic signed [30:0]   INV_GAIN  = 31'sd652032874;   // 1/K in Q1.30
	localparam logic signed [ZW-1:0] PI_Q      = 20'sd205887;
	localparam logic signed [ZW-1:0] HALF_PI_Q = 20'sd102944;

	localparam logic [3:0] OP_ADD  = 4'd0;
	localparam logic [3:0] OP_SUB  = 4'd1;
	localparam logic [3:0] OP_MUL  = 4'd2;
	localparam logic [3:0] OP_DIV  = 4'd3;
	localparam logic [3:0] OP_NORM = 4'd4;
	localparam logic [3:0] OP_ROT  = 4'd5;
	localparam logic [3:0] OP_RFL  = 4'd6;
	localparam logic [3:0] OP_MAG  = 4'd7;
	localparam logic [3:0] OP_DOT  = 4'd8;

	// request state through the root and divide stages
	typedef struct packed {
		logic [3:0]             op;
		logic signed [31:0]     ax;
		logic signed [31:0]     ay;
		logic signed [31:0]     bx;
		logic signed [31:0]     by;
		logic signed [CW-1:0]   cx;
		logic signed [CW-1:0]   cy;
		logic signed [ZW-1:0]   cz;
		logic [63:0]            sq;     // radicand, then remainder
		logic [RB-1:0]          root;
		logic [NW-1:0]          rxr;    // divide remainders
		logic [NW-1:0]          ryr;
		logic [31:0]            dx;     // divisors
		logic [31:0]            dy;
		logic [QB-1:0]          qx;
		logic [QB-1:0]          qy;
		logic                   ovx;
		logic                   ovy;
		logic                   sgx;
		logic                   sgy;
	} pipe_t;

	// request state after the divider
	typedef struct packed {
		logic [3:0]         op;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] vx;     // divide or normalize result
		logic signed [31:0] vy;
		logic signed [31:0] rotx;
		logic signed [31:0] roty;
		logic signed [31:0] mag;
		logic               skip;
	} post_t;

	function automatic logic signed [ZW-1:0] atan_q(input int idx);
		case (idx)
			0:  return 20'sd51472;
			1:  return 20'sd30386;
			2:  return 20'sd16055;
			3:  return 20'sd8150;
			4:  return 20'sd4091;
			5:  return 20'sd2047;
			6:  return 20'sd1024;
			7:  return 20'sd512;
			8:  return 20'sd256;
			9:  return 20'sd128;
			10: return 20'sd64;
			11: return 20'sd32;
			12: return 20'sd16;
			13: return 20'sd8;
			14: return 20'sd4;
			15: return 20'sd2;
			16: return 20'sd1;
			default: return '0;
		endcase
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -66'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	// magnitude; the most negative value maps to 2^31, which fits unsigned
	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		logic signed [31:0] n;
		n = -v;
		return v[31] ? n : v;
	endfunction

endpackage

// File: src/v2a_sqrt.sv
// v2a_sqrt: 32-stage integer square root, one result bit per stage, with the
// 17 rotation micro-steps riding along in the first stages. Depends on v2a_pkg.
module v2a_sqrt (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  v2a_pkg::pipe_t   in_p,
	output logic             out_vld,
	output v2a_pkg::pipe_t   out_p
);

	v2a_pkg::pipe_t                pipe_s [1:v2a_pkg::RB];
	logic [v2a_pkg::RB:1]          vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[v2a_pkg::RB-1:1], in_vld};
		end
	end

	for (genvar k = 0; k < v2a_pkg::RB; k++) begin : g_stage
		localparam int BI = v2a_pkg::RB - 1 - k;
		v2a_pkg::pipe_t cur;
		v2a_pkg::pipe_t nxt;
		logic [63:0] trial;
		logic signed [v2a_pkg::CW-1:0] dxs;
		logic signed [v2a_pkg::CW-1:0] dys;

		if (k == 0) begin : g_first
			assign cur = in_p;
		end else begin : g_next
			assign cur = pipe_s[k];
		end

		always_comb begin
			nxt   = cur;
			trial = (64'(cur.root) << (BI + 1)) + (64'd1 << (2 * BI));
			dxs   = cur.cy >>> k;
			dys   = cur.cx >>> k;
			if (cur.sq >= trial) begin
				nxt.sq   = cur.sq - trial;
				nxt.root = cur.root | (32'd1 << BI);
			end
			if (k < v2a_pkg::ROT_STEPS) begin
				// non-negative residual rotates counterclockwise
				if (!cur.cz[v2a_pkg::ZW-1]) begin
					nxt.cx = cur.cx - dxs;
					nxt.cy = cur.cy + dys;
					nxt.cz = cur.cz - v2a_pkg::atan_q(k);
				end else begin
					nxt.cx = cur.cx + dxs;
					nxt.cy = cur.cy - dys;
					nxt.cz = cur.cz + v2a_pkg::atan_q(k);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pipe_s[k+1] <= nxt;
			end
		end
	end

	assign out_vld = vld_s[v2a_pkg::RB];
	assign out_p   = pipe_s[v2a_pkg::RB];

	// floor root: remainder never exceeds twice the root
	a_root_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[v2a_pkg::RB] |->
			pipe_s[v2a_pkg::RB].sq <= {31'b0, pipe_s[v2a_pkg::RB].root, 1'b0})
		else $error("root remainder out of range");

endmodule

// File: src/v2a_div.sv
// v2a_div: pipelined restoring divider for both components (divide and
// normalize), then sign, saturation and zero-case handling. Depends on v2a_pkg.
module v2a_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  v2a_pkg::pipe_t   in_p,
	output logic             out_vld,
	output v2a_pkg::post_t   out_p
);

	v2a_pkg::pipe_t          pipe_s [0:v2a_pkg::QB];
	v2a_pkg::pipe_t          setup_c;
	v2a_pkg::post_t          post_c;
	v2a_pkg::post_t          post_s;
	logic [v2a_pkg::QB+1:0]  vld_s;
	logic signed [31:0]      vsx_c;
	logic signed [31:0]      vsy_c;
	logic signed [31:0]      qsx_c;
	logic signed [31:0]      qsy_c;

	function automatic logic signed [31:0] q_signed(input logic [v2a_pkg::QB-1:0] q,
		input logic ov, input logic sg);
		logic [v2a_pkg::QB-1:0] n;
		n = -q;
		if (ov)
			return sg ? 32'sh80000000 : 32'sh7fffffff;
		else if (sg)
			return (q > 33'h080000000) ? 32'sh80000000 : n[31:0];
		else
			return (q > 33'h07fffffff) ? 32'sh7fffffff : q[31:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[v2a_pkg::QB:0], in_vld};
		end
	end

	// operand setup: divide uses B as divisor, normalize and reflect the root
	always_comb begin
		setup_c = in_p;
		vsx_c   = (in_p.op == v2a_pkg::OP_RFL) ? in_p.bx : in_p.ax;
		vsy_c   = (in_p.op == v2a_pkg::OP_RFL) ? in_p.by : in_p.ay;
		setup_c.qx  = '0;
		setup_c.qy  = '0;
		setup_c.ovx = 1'b0;
		setup_c.ovy = 1'b0;
		if (in_p.op == v2a_pkg::OP_DIV) begin
			setup_c.rxr = {v2a_pkg::mag32(in_p.ax), 16'b0};
			setup_c.ryr = {v2a_pkg::mag32(in_p.ay), 16'b0};
			setup_c.dx  = v2a_pkg::mag32(in_p.bx);
			setup_c.dy  = v2a_pkg::mag32(in_p.by);
			setup_c.sgx = in_p.ax[31] ^ in_p.bx[31];
			setup_c.sgy = in_p.ay[31] ^ in_p.by[31];
		end else begin
			setup_c.rxr = {v2a_pkg::mag32(vsx_c), 16'b0};
			setup_c.ryr = {v2a_pkg::mag32(vsy_c), 16'b0};
			setup_c.dx  = in_p.root;
			setup_c.dy  = in_p.root;
			setup_c.sgx = vsx_c[31];
			setup_c.sgy = vsy_c[31];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s[0] <= setup_c;
		end
	end

	for (genvar j = 0; j < v2a_pkg::QB; j++) begin : g_step
		localparam int BI = v2a_pkg::QB - 1 - j;
		v2a_pkg::pipe_t nxt;
		logic [v2a_pkg::CMPW-1:0] cand_x;
		logic [v2a_pkg::CMPW-1:0] cand_y;

		always_comb begin
			nxt    = pipe_s[j];
			cand_x = v2a_pkg::CMPW'(pipe_s[j].dx) << BI;
			cand_y = v2a_pkg::CMPW'(pipe_s[j].dy) << BI;
			if (v2a_pkg::CMPW'(pipe_s[j].rxr) >= cand_x) begin
				nxt.rxr    = pipe_s[j].rxr - cand_x[v2a_pkg::NW-1:0];
				nxt.qx[BI] = 1'b1;
			end
			if (v2a_pkg::CMPW'(pipe_s[j].ryr) >= cand_y) begin
				nxt.ryr    = pipe_s[j].ryr - cand_y[v2a_pkg::NW-1:0];
				nxt.qy[BI] = 1'b1;
			end
			// quotient too wide for the kept bits: saturate later
			if (j == 0) begin
				nxt.ovx = v2a_pkg::CMPW'(pipe_s[j].rxr) >=
					(v2a_pkg::CMPW'(pipe_s[j].dx) << v2a_pkg::QB);
				nxt.ovy = v2a_pkg::CMPW'(pipe_s[j].ryr) >=
					(v2a_pkg::CMPW'(pipe_s[j].dy) << v2a_pkg::QB);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pipe_s[j+1] <= nxt;
			end
		end
	end

	always_comb begin
		qsx_c       = q_signed(pipe_s[v2a_pkg::QB].qx, pipe_s[v2a_pkg::QB].ovx,
			pipe_s[v2a_pkg::QB].sgx);
		qsy_c       = q_signed(pipe_s[v2a_pkg::QB].qy, pipe_s[v2a_pkg::QB].ovy,
			pipe_s[v2a_pkg::QB].sgy);
		post_c.op   = pipe_s[v2a_pkg::QB].op;
		post_c.ax   = pipe_s[v2a_pkg::QB].ax;
		post_c.ay   = pipe_s[v2a_pkg::QB].ay;
		post_c.bx   = pipe_s[v2a_pkg::QB].bx;
		post_c.by   = pipe_s[v2a_pkg::QB].by;
		post_c.rotx = v2a_pkg::sat32(66'(pipe_s[v2a_pkg::QB].cx >>> v2a_pkg::GUARD));
		post_c.roty = v2a_pkg::sat32(66'(pipe_s[v2a_pkg::QB].cy >>> v2a_pkg::GUARD));
		post_c.mag  = v2a_pkg::sat32(66'(pipe_s[v2a_pkg::QB].root));
		post_c.skip = 1'b0;
		post_c.vx   = qsx_c;
		post_c.vy   = qsy_c;
		if (pipe_s[v2a_pkg::QB].op == v2a_pkg::OP_DIV) begin
			if (pipe_s[v2a_pkg::QB].bx == '0 || pipe_s[v2a_pkg::QB].by == '0) begin
				post_c.vx   = pipe_s[v2a_pkg::QB].ax;
				post_c.vy   = pipe_s[v2a_pkg::QB].ay;
				post_c.skip = 1'b1;
			end
		end else if (pipe_s[v2a_pkg::QB].root == '0) begin
			// zero vector normalizes to zero
			post_c.vx = '0;
			post_c.vy = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			post_s <= post_c;
		end
	end

	assign out_vld = vld_s[v2a_pkg::QB+1];
	assign out_p   = post_s;

	// a unit vector quotient never overflows and stays within one
	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[v2a_pkg::QB] && (pipe_s[v2a_pkg::QB].op == v2a_pkg::OP_NORM ||
		pipe_s[v2a_pkg::QB].op == v2a_pkg::OP_RFL) && pipe_s[v2a_pkg::QB].root != '0 |->
			!pipe_s[v2a_pkg::QB].ovx && pipe_s[v2a_pkg::QB].qx <= 33'd65536)
		else $error("normalize quotient out of range");

endmodule

// File: src/vector2_alu_top.sv
// vector2_alu_top: 2-D Q16.16 vector ALU, fully pipelined.
// Depends on v2a_pkg, v2a_sqrt and v2a_div.
//
//   channel   signals                                   direction
//   in        in_valid/in_ready, opcode a_x a_y b_x b_y angle   request in
//   out       out_valid/out_ready, res_x res_y res_scalar divide_skipped  result out
//
// One request per cycle unless a result waits untaken at the output.
// Requests pass the 32-stage root and the 33-step divider in series.
// Reset clears only the valid bits of each stage.
// A stall freezes every stage; in_ready is low only while a result waits untaken.
module vector2_alu_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         opcode,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [18:0] angle,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] res_x,
	output logic signed [31:0] res_y,
	output logic signed [31:0] res_scalar,
	output logic               divide_skipped
);

	logic en;

	// stage 1: input register
	logic               vld_s1;
	logic [3:0]         op_s1;
	logic signed [31:0] ax_s1, ay_s1, bx_s1, by_s1;
	logic signed [18:0] ang_s1;

	// stage 2: squares and gain products
	logic               vld_s2;
	logic [3:0]         op_s2;
	logic signed [31:0] ax_s2, ay_s2, bx_s2, by_s2;
	logic [63:0]        sqx_s2, sqy_s2;
	logic signed [62:0] kx_s2, ky_s2;
	logic               neg_s2;
	logic signed [v2a_pkg::ZW-1:0] z_s2;

	logic signed [31:0] vx_c, vy_c;
	logic [31:0]        ux_c, uy_c;
	logic [63:0]        sqx_c, sqy_c;
	logic signed [62:0] kx_c, ky_c;
	logic signed [v2a_pkg::ZW-1:0] za_c, zc_c;
	logic               neg_c;

	// stage 3: radicand and scaled rotation start
	logic               vld_s3;
	v2a_pkg::pipe_t     pipe_s3;
	v2a_pkg::pipe_t     p3_c;
	logic signed [62:0] knx_c, kny_c;

	logic               vld_rt;
	v2a_pkg::pipe_t     pipe_rt;
	logic               vld_s70;
	v2a_pkg::post_t     post_s70;

	// stages 71..74: dot and reflect tail
	logic               vld_s71, vld_s72, vld_s73, vld_s74;
	v2a_pkg::post_t     pt_s71, pt_s72, pt_s73;
	logic signed [31:0] mx_c, my_c;
	logic signed [63:0] px_c, py_c;
	logic signed [63:0] px_s71, py_s71;
	logic signed [64:0] dsum_c;
	logic signed [64:0] dsh_c;
	logic signed [33:0] d_s72;
	logic signed [31:0] dot_s72, fx_s72, fy_s72;
	logic signed [51:0] rpx_c, rpy_c;
	logic signed [51:0] rpx_s73, rpy_s73;
	logic signed [31:0] dot_s73, fx_s73, fy_s73;
	logic signed [65:0] rfx_c, rfy_c;
	logic signed [31:0] rx_c, ry_c, rs_c;
	logic               sk_c;
	logic signed [31:0] res_x_s74, res_y_s74, res_s_s74;
	logic               skip_s74;

	assign en       = !vld_s74 || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s71 <= 1'b0;
			vld_s72 <= 1'b0;
			vld_s73 <= 1'b0;
			vld_s74 <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s71 <= vld_s70;
			vld_s72 <= vld_s71;
			vld_s73 <= vld_s72;
			vld_s74 <= vld_s73;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1  <= opcode;
			ax_s1  <= a_x;
			ay_s1  <= a_y;
			bx_s1  <= b_x;
			by_s1  <= b_y;
			ang_s1 <= angle;
		end
	end

	// root operand: the normal for reflect, A otherwise
	always_comb begin
		vx_c  = (op_s1 == v2a_pkg::OP_RFL) ? bx_s1 : ax_s1;
		vy_c  = (op_s1 == v2a_pkg::OP_RFL) ? by_s1 : ay_s1;
		ux_c  = v2a_pkg::mag32(vx_c);
		uy_c  = v2a_pkg::mag32(vy_c);
		sqx_c = ux_c * ux_c;
		sqy_c = uy_c * uy_c;
		kx_c  = ax_s1 * v2a_pkg::INV_GAIN;
		ky_c  = ay_s1 * v2a_pkg::INV_GAIN;
		// fold the angle into +-pi/2 by turning A half way round
		za_c  = v2a_pkg::ZW'(ang_s1);
		zc_c  = za_c;
		neg_c = 1'b0;
		if (za_c > v2a_pkg::HALF_PI_Q) begin
			zc_c  = za_c - v2a_pkg::PI_Q;
			neg_c = 1'b1;
		end else if (za_c < -v2a_pkg::HALF_PI_Q) begin
			zc_c  = za_c + v2a_pkg::PI_Q;
			neg_c = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2  <= op_s1;
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			bx_s2  <= bx_s1;
			by_s2  <= by_s1;
			sqx_s2 <= sqx_c;
			sqy_s2 <= sqy_c;
			kx_s2  <= kx_c;
			ky_s2  <= ky_c;
			neg_s2 <= neg_c;
			z_s2   <= zc_c;
		end
	end

	always_comb begin
		knx_c   = neg_s2 ? -kx_s2 : kx_s2;
		kny_c   = neg_s2 ? -ky_s2 : ky_s2;
		p3_c    = '0;
		p3_c.op = op_s2;
		p3_c.ax = ax_s2;
		p3_c.ay = ay_s2;
		p3_c.bx = bx_s2;
		p3_c.by = by_s2;
		p3_c.sq = sqx_s2 + sqy_s2;
		p3_c.cx = v2a_pkg::CW'(knx_c >>> v2a_pkg::SHIFT_K);
		p3_c.cy = v2a_pkg::CW'(kny_c >>> v2a_pkg::SHIFT_K);
		p3_c.cz = z_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s3 <= p3_c;
		end
	end

	v2a_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s3),
		.in_p    (pipe_s3),
		.out_vld (vld_rt),
		.out_p   (pipe_rt)
	);

	v2a_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_rt),
		.in_p    (pipe_rt),
		.out_vld (vld_s70),
		.out_p   (post_s70)
	);

	// products: A with the unit normal for reflect, A with B otherwise
	always_comb begin
		mx_c = (post_s70.op == v2a_pkg::OP_RFL) ? post_s70.vx : post_s70.bx;
		my_c = (post_s70.op == v2a_pkg::OP_RFL) ? post_s70.vy : post_s70.by;
		px_c = post_s70.ax * mx_c;
		py_c = post_s70.ay * my_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s71 <= post_s70;
			px_s71 <= px_c;
			py_s71 <= py_c;
		end
	end

	assign dsum_c = 65'(px_s71) + 65'(py_s71);
	assign dsh_c  = dsum_c >>> v2a_pkg::FRAC;

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s72  <= pt_s71;
			d_s72   <= 34'(dsh_c);
			dot_s72 <= v2a_pkg::sat32(66'(dsh_c));
			fx_s72  <= v2a_pkg::sat32(66'(px_s71 >>> v2a_pkg::FRAC));
			fy_s72  <= v2a_pkg::sat32(66'(py_s71 >>> v2a_pkg::FRAC));
		end
	end

	assign rpx_c = d_s72 * signed'(pt_s72.vx[17:0]);
	assign rpy_c = d_s72 * signed'(pt_s72.vy[17:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s73  <= pt_s72;
			rpx_s73 <= rpx_c;
			rpy_s73 <= rpy_c;
			dot_s73 <= dot_s72;
			fx_s73  <= fx_s72;
			fy_s73  <= fy_s72;
		end
	end

	assign rfx_c = 66'(pt_s73.ax) - (66'(rpx_s73 >>> v2a_pkg::FRAC) <<< 1);
	assign rfy_c = 66'(pt_s73.ay) - (66'(rpy_s73 >>> v2a_pkg::FRAC) <<< 1);

	always_comb begin
		rx_c = '0;
		ry_c = '0;
		rs_c = '0;
		sk_c = 1'b0;
		case (pt_s73.op)
			v2a_pkg::OP_ADD: begin
				rx_c = v2a_pkg::sat32(66'(pt_s73.ax) + 66'(pt_s73.bx));
				ry_c = v2a_pkg::sat32(66'(pt_s73.ay) + 66'(pt_s73.by));
			end
			v2a_pkg::OP_SUB: begin
				rx_c = v2a_pkg::sat32(66'(pt_s73.ax) - 66'(pt_s73.bx));
				ry_c = v2a_pkg::sat32(66'(pt_s73.ay) - 66'(pt_s73.by));
			end
			v2a_pkg::OP_MUL: begin
				rx_c = fx_s73;
				ry_c = fy_s73;
			end
			v2a_pkg::OP_DIV: begin
				rx_c = pt_s73.vx;
				ry_c = pt_s73.vy;
				sk_c = pt_s73.skip;
			end
			v2a_pkg::OP_NORM: begin
				rx_c = pt_s73.vx;
				ry_c = pt_s73.vy;
			end
			v2a_pkg::OP_ROT: begin
				rx_c = pt_s73.rotx;
				ry_c = pt_s73.roty;
			end
			v2a_pkg::OP_RFL: begin
				rx_c = v2a_pkg::sat32(rfx_c);
				ry_c = v2a_pkg::sat32(rfy_c);
			end
			v2a_pkg::OP_MAG: begin
				rs_c = pt_s73.mag;
			end
			v2a_pkg::OP_DOT: begin
				rs_c = dot_s73;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_x_s74 <= rx_c;
			res_y_s74 <= ry_c;
			res_s_s74 <= rs_c;
			skip_s74  <= sk_c;
		end
	end

	assign out_valid      = vld_s74;
	assign res_x          = res_x_s74;
	assign res_y          = res_y_s74;
	assign res_scalar     = res_s_s74;
	assign divide_skipped = skip_s74;

	// each component of the normal fed to reflect lies within plus or minus one
	a_rfl_unit: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s71 && pt_s71.op == v2a_pkg::OP_RFL |->
			pt_s71.vx <= 32'sd65536 && pt_s71.vx >= -32'sd65536 &&
			pt_s71.vy <= 32'sd65536 && pt_s71.vy >= -32'sd65536)
		else $error("reflect normal not unit length");

	// a skipped divide is a vector result, never a scalar one
	a_skip_scalar: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s74 && skip_s74 |-> res_s_s74 == '0)
		else $error("divide skip with scalar result");

	// a held result keeps the tail frozen
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s74 && !out_ready |=> $stable(vld_s73) && $stable(vld_s70))
		else $error("pipeline moved during stall");

endmodule
